### rtl/core/crs_pkg.sv
// Shared types and codes for the countdown priority routine scheduler.
// No dependencies.
`timescale 1ns / 1ps

package crs_pkg;

	// request kinds carried on s_tuser
	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_TICK   = 2'd2
	} req_t;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	// one table row as stored in the RAM
	typedef struct packed {
		logic [7:0] id;
		logic [7:0] period;
		logic [7:0] countdown;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// result beat, status in the low bits
	typedef struct packed {
		logic [4:0] entry_count;
		logic [7:0] served_id;
		logic       served_valid;
		logic [1:0] status;
	} res_t;

	localparam int unsigned RES_W = $bits(res_t);

endpackage

### rtl/core/countdown_priority_routine_scheduler_unit.sv
// Top level of the countdown priority routine scheduler.
// Depends on crs_pkg, crs_ram, crs_ctrl, crs_out.
// Add and unknown requests go from the done state through the output register to m_tvalid; cancel and
// tick first walk a non-empty table via its one read port. Only one request is in flight at a time.
// Reset: arst_n clears the entry count and handshake state; table RAM contents are not cleared.
`timescale 1ns / 1ps

module countdown_priority_routine_scheduler_unit #(
	parameter int unsigned MAX_ROUTINES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,   // routine_id[7:0], period[15:8]
	input  logic [1:0]                s_tuser,   // req_type[1:0]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [crs_pkg::RES_W-1:0] m_tdata    // status[1:0], served_valid[2],
	                                             // served_id[10:3], entry_count[15:11]
);
	import crs_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ROUTINES);

	// Table rows (id, period, countdown) live in one RAM, kept in table order.
	// Rows below the entry count are always written, so no read sees stale data.
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	entry_t          ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	logic            res_valid;
	logic            res_ready;
	res_t            res;

	crs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ROUTINES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer: streams reads one row a cycle; the row read last cycle is
	// updated (tick) or copied one place down (cancel after the match).
	// Writes only touch rows already read, so no forwarding is needed.
	crs_ctrl #(
		.MAX_ROUTINES (MAX_ROUTINES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (req_t'(s_tuser)),
		.in_id     (s_tdata[7:0]),
		.in_period (s_tdata[15:8]),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (entry_t'(ram_rdata)),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: a finished beat waits here while the next request runs.
	crs_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### rtl/core/crs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module crs_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/crs_ctrl.sv
// Request sequencer: add, cancel-with-close-up and countdown tick over the table RAM.
// Depends on crs_pkg.
`timescale 1ns / 1ps

module crs_ctrl #(
	parameter int unsigned MAX_ROUTINES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request side
	input  logic                            in_valid,
	output logic                            in_ready,
	input  crs_pkg::req_t                   in_req,
	input  logic [7:0]                      in_id,
	input  logic [7:0]                      in_period,
	// table RAM
	output logic                            ram_we,
	output logic [$clog2(MAX_ROUTINES)-1:0] ram_waddr,
	output crs_pkg::entry_t                 ram_wdata,
	output logic                            ram_re,
	output logic [$clog2(MAX_ROUTINES)-1:0] ram_raddr,
	input  crs_pkg::entry_t                 ram_rdata,
	// result side
	output logic                            res_valid,
	input  logic                            res_ready,
	output crs_pkg::res_t                   res
);
	import crs_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ROUTINES);
	localparam int unsigned CW = $clog2(MAX_ROUTINES + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   rd_ptr_q;
	req_t            req_q;
	logic [7:0]      id_q;
	logic            found_q;
	res_t            res_q;
	logic            rvalid_s1;
	logic [AW-1:0]   idx_s1;

	logic            accept;
	logic            rd_en;
	logic            fin;
	logic            last;
	logic            hit_id;
	logic            zero;
	logic [7:0]      cd_dec;
	entry_t          e;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	assign e      = ram_rdata;
	assign hit_id = (e.id == id_q);
	assign cd_dec = e.countdown - 8'd1;
	assign zero   = (cd_dec == 8'd0);
	assign last   = (CW'(idx_s1) == cnt_q - CW'(1));

	always_comb begin
		fin = 1'b0;
		if (state_q == S_SCAN && rvalid_s1) begin
			fin = last || (req_q == REQ_TICK && zero);
		end
	end

	assign rd_en     = (state_q == S_SCAN) && (rd_ptr_q < cnt_q) && !fin;
	assign ram_re    = rd_en;
	assign ram_raddr = rd_ptr_q[AW-1:0];

	// one write port: append on add, write-back on tick, close-up on cancel
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = e;
		if (accept && in_req == REQ_ADD && cnt_q != CW'(MAX_ROUTINES)) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q[AW-1:0];
			ram_wdata = '{id: in_id, period: in_period, countdown: in_period};
		end else if (state_q == S_SCAN && rvalid_s1) begin
			if (req_q == REQ_TICK) begin
				ram_we    = 1'b1;
				ram_waddr = idx_s1;
				ram_wdata = '{id: e.id, period: e.period,
					countdown: zero ? e.period : cd_dec};
			end else if (found_q) begin
				// shift this row down over the removed one
				ram_we    = 1'b1;
				ram_waddr = idx_s1 - AW'(1);
				ram_wdata = e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_ptr_q  <= '0;
			found_q   <= 1'b0;
			rvalid_s1 <= 1'b0;
			idx_s1    <= '0;
		end else begin
			rvalid_s1 <= rd_en;
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
				idx_s1   <= rd_ptr_q[AW-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_ptr_q <= '0;
						found_q  <= 1'b0;
						case (in_req) inside
							REQ_ADD: begin
								state_q <= S_DONE;
								if (cnt_q != CW'(MAX_ROUTINES)) begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							REQ_CANCEL, REQ_TICK: begin
								if (cnt_q != '0) begin
									state_q <= S_SCAN;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rvalid_s1 && req_q == REQ_CANCEL && hit_id) begin
						found_q <= 1'b1;
					end
					if (fin) begin
						state_q <= S_DONE;
						if (req_q == REQ_CANCEL && (found_q || hit_id)) begin
							cnt_q <= cnt_q - CW'(1);
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_req;
			id_q  <= in_id;
			if (in_req == REQ_ADD && cnt_q != CW'(MAX_ROUTINES)) begin
				res_q <= '{entry_count: 5'(cnt_q + CW'(1)), served_id: 8'd0,
					served_valid: 1'b0, status: ST_OK};
			end else if (in_req == REQ_ADD) begin
				res_q <= '{entry_count: 5'(cnt_q), served_id: 8'd0,
					served_valid: 1'b0, status: ST_FULL};
			end else begin
				res_q <= '{entry_count: 5'(cnt_q), served_id: 8'd0,
					served_valid: 1'b0, status: ST_MISS};
			end
		end else if (fin) begin
			if (req_q == REQ_TICK) begin
				if (zero) begin
					res_q <= '{entry_count: res_q.entry_count, served_id: e.id,
						served_valid: 1'b1, status: ST_OK};
				end
			end else if (found_q || hit_id) begin
				res_q <= '{entry_count: 5'(cnt_q - CW'(1)), served_id: 8'd0,
					served_valid: 1'b0, status: ST_OK};
			end
		end
	end

endmodule

### rtl/core/crs_out.sv
// Output register for result beats; frees the sequencer while a beat waits.
// Depends on crs_pkg.
`timescale 1ns / 1ps

module crs_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      res_valid,
	output logic                      res_ready,
	input  crs_pkg::res_t             res,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [crs_pkg::RES_W-1:0] m_tdata
);
	import crs_pkg::*;

	logic load;

	assign res_ready = !m_tvalid || m_tready;
	assign load      = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res_ready) begin
			m_tvalid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= res;
		end
	end

endmodule

### rtl/core/crs_checker.sv
// Port-level checks for the scheduler top level, attached by bind.
// Depends on crs_pkg and countdown_priority_routine_scheduler_unit.
`timescale 1ns / 1ps

module crs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [15:0]               s_tdata,
	input logic [1:0]                s_tuser,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [crs_pkg::RES_W-1:0] m_tdata
);
	import crs_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one request in flight: no accept on the cycle after an accept
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// a served routine always carries ok status
	a_served_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == ST_OK)
		else $error("served beat without ok status");

	// no served id unless a routine was served
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[10:3] == 8'd0)
		else $error("served id set on unserved beat");

endmodule

bind countdown_priority_routine_scheduler_unit crs_checker u_crs_checker (.*);

### tb/sv/tb_countdown_priority_routine_scheduler_unit.sv
// Self-checking testbench for countdown_priority_routine_scheduler_unit.
// Drives add, cancel, tick and unknown requests; checks each beat against a local predictor.
// Depends on crs_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_countdown_priority_routine_scheduler_unit;
	import crs_pkg::*;

	localparam int unsigned MAX_ROUTINES = 16;
	localparam logic [1:0]  REQ_UNKNOWN  = 2'd3;   // unused request code, must be ignored
	localparam int          RAND_ITEMS   = 520;
	localparam int          DRAIN_CYCLES = 40;
	localparam int          STALL_LIMIT  = 2000;   // cycles with no beat on either side

	typedef struct {
		logic [1:0] req;
		logic [7:0] id;
		logic [7:0] per;
		int         reps;    // row repeated with id and period stepped by one
		bit         typed;   // expectation written out below instead of predicted
		res_t       want;
	} dir_row_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata  = '0;
	logic [1:0]        s_tuser  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [RES_W-1:0]  m_tdata;

	// predictor copy of the routine table
	logic [7:0] tbl_id  [MAX_ROUTINES];
	logic [7:0] tbl_per [MAX_ROUTINES];
	logic [7:0] tbl_cd  [MAX_ROUTINES];
	int         tbl_count = 0;

	res_t       expected_results [$];
	dir_row_t   dir_rows [$];
	res_t       got_beat, want_beat;
	int         fails       = 0;
	int         idle_cycles = 0;
	int         tx_idle_pct = 32;
	int         rx_idle_pct = 56;

	countdown_priority_routine_scheduler_unit #(
		.MAX_ROUTINES(MAX_ROUTINES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic res_t mk_res(input logic [1:0] st, input logic v,
			input logic [7:0] sid, input logic [4:0] cnt);
		res_t r;
		r.status       = st;
		r.served_valid = v;
		r.served_id    = sid;
		r.entry_count  = cnt;
		return r;
	endfunction

	// Applies one request to the table copy and returns the result beat it should produce.
	function automatic res_t sched_apply(input logic [1:0] req, input logic [7:0] id,
			input logic [7:0] per);
		res_t r;
		int   hit;
		int   i;
		bit   served;
		r        = '0;
		r.status = ST_MISS;
		hit      = -1;
		served   = 1'b0;
		case (req)
			REQ_ADD: begin
				if (tbl_count >= MAX_ROUTINES) begin
					r.status = ST_FULL;
				end else begin
					tbl_id[tbl_count]  = id;
					tbl_per[tbl_count] = per;
					tbl_cd[tbl_count]  = per;
					tbl_count++;
					r.status = ST_OK;
				end
			end
			REQ_CANCEL: begin
				for (i = 0; i < tbl_count; i++)
					if (hit < 0 && tbl_id[i] == id)
						hit = i;
				if (hit >= 0) begin
					// later entries close up, order kept
					for (i = hit; i + 1 < tbl_count; i++) begin
						tbl_id[i]  = tbl_id[i + 1];
						tbl_per[i] = tbl_per[i + 1];
						tbl_cd[i]  = tbl_cd[i + 1];
					end
					tbl_count--;
					r.status = ST_OK;
				end
			end
			REQ_TICK: begin
				// walk stops at the first countdown that hits zero
				for (i = 0; i < tbl_count && !served; i++) begin
					tbl_cd[i] = tbl_cd[i] - 8'd1;
					if (tbl_cd[i] == 8'd0) begin
						tbl_cd[i]      = tbl_per[i];
						r.served_valid = 1'b1;
						r.served_id    = tbl_id[i];
						r.status       = ST_OK;
						served         = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.entry_count = tbl_count[4:0];
		return r;
	endfunction

	task automatic add_row(input logic [1:0] req, input logic [7:0] id, input logic [7:0] per,
			input int reps, input bit typed, input res_t want);
		dir_row_t row;
		row.req   = req;
		row.id    = id;
		row.per   = per;
		row.reps  = reps;
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endtask

	// Offers one request beat, with random idle cycles before it, and records its expectation.
	task automatic send_request(input logic [1:0] req, input logic [7:0] id,
			input logic [7:0] per, input bit typed, input res_t want);
		res_t pred;
		bit   placed;
		placed = 1'b0;
		while (!placed) begin
			@(negedge clk);
			if ($urandom_range(0, 99) < tx_idle_pct) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= {per, id};
				s_tuser  <= req;
				placed = 1'b1;
			end
		end
		do @(posedge clk); while (!s_tready);
		pred = sched_apply(req, id, per);
		expected_results.push_back(typed ? want : pred);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endtask

	// result side stall pattern
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_beat = m_tdata;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h", $time,
					got_beat);
				fails++;
			end else begin
				want_beat = expected_results.pop_front();
				check_field("status", want_beat.status, got_beat.status);
				check_field("served_valid", want_beat.served_valid, got_beat.served_valid);
				check_field("served_id", want_beat.served_id, got_beat.served_id);
				check_field("entry_count", want_beat.entry_count, got_beat.entry_count);
			end
		end
	end

	// watchdog on cycles with no beat accepted anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin : stimulus
		dir_row_t   row;
		logic [1:0] req;
		logic [7:0] id;
		logic [7:0] per;
		int         mode;
		int         r;
		int         k;
		int         n;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table: tick, cancel and an unknown code all miss
		add_row(REQ_TICK,    8'h00, 8'h00, 1, 1'b1, mk_res(ST_MISS, 1'b0, 8'h00, 5'd0));
		add_row(REQ_CANCEL,  8'h00, 8'h00, 1, 1'b1, mk_res(ST_MISS, 1'b0, 8'h00, 5'd0));
		add_row(REQ_UNKNOWN, 8'hff, 8'hff, 1, 1'b1, mk_res(ST_MISS, 1'b0, 8'h00, 5'd0));
		// period 1 serves on the very next tick
		add_row(REQ_ADD,     8'h00, 8'h01, 1, 1'b1, mk_res(ST_OK,   1'b0, 8'h00, 5'd1));
		add_row(REQ_TICK,    8'h00, 8'h00, 1, 1'b1, mk_res(ST_OK,   1'b1, 8'h00, 5'd1));
		add_row(REQ_CANCEL,  8'h00, 8'h00, 1, 1'b1, mk_res(ST_OK,   1'b0, 8'h00, 5'd0));
		// period 0 wraps to 256, duplicate ids, max period
		add_row(REQ_ADD,     8'hff, 8'h00, 1, 1'b1, mk_res(ST_OK,   1'b0, 8'h00, 5'd1));
		add_row(REQ_ADD,     8'h5a, 8'h02, 1, 1'b0, '0);
		add_row(REQ_ADD,     8'h5a, 8'h03, 1, 1'b0, '0);
		add_row(REQ_ADD,     8'h80, 8'hff, 1, 1'b0, '0);
		add_row(REQ_TICK,    8'h00, 8'h00, 1, 1'b0, '0);
		add_row(REQ_TICK,    8'h00, 8'h00, 1, 1'b0, '0);
		// first duplicate goes, then a miss
		add_row(REQ_CANCEL,  8'h5a, 8'h00, 1, 1'b0, '0);
		add_row(REQ_CANCEL,  8'h33, 8'h00, 1, 1'b0, '0);
		// fill up, then overflow
		add_row(REQ_ADD,     8'h10, 8'h01, 13, 1'b0, '0);
		add_row(REQ_ADD,     8'h55, 8'haa, 1, 1'b1, mk_res(ST_FULL, 1'b0, 8'h00, 5'd16));
		add_row(REQ_TICK,    8'h00, 8'h00, 1, 1'b0, '0);
		add_row(REQ_UNKNOWN, 8'h00, 8'h00, 1, 1'b1, mk_res(ST_MISS, 1'b0, 8'h00, 5'd16));
		// remove head and tail of a full table
		add_row(REQ_CANCEL,  8'hff, 8'h00, 1, 1'b0, '0);
		add_row(REQ_CANCEL,  8'h1c, 8'h00, 1, 1'b0, '0);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			for (k = 0; k < row.reps; k++)
				send_request(row.req, row.id + 8'(k), row.per + 8'(k), row.typed, row.want);
		end

		mode = 0;
		for (n = 0; n < RAND_ITEMS; n++) begin
			// idle profile: sender light / receiver heavy, then swapped, then none
			case (n * 3 / RAND_ITEMS)
				0: begin tx_idle_pct = 32; rx_idle_pct = 56; end
				1: begin tx_idle_pct = 56; rx_idle_pct = 32; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			// every 40 beats lean the mix toward growing or shrinking the table
			if (n % 40 == 0)
				mode = $urandom_range(0, 2);
			r   = $urandom_range(0, 99);
			id  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
			                                  : 8'($urandom_range(0, 255));
			per = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 6))
			                                 : 8'($urandom_range(0, 255));
			if (r < 4) begin
				req = REQ_UNKNOWN;
			end else if (r < (mode == 1 ? 50 : (mode == 2 ? 15 : 32))) begin
				req = REQ_ADD;
			end else if (r < (mode == 2 ? 55 : 52)) begin
				req = REQ_CANCEL;
				// mostly hit a held entry
				if (tbl_count > 0 && $urandom_range(0, 9) != 0)
					id = tbl_id[$urandom_range(0, tbl_count - 1)];
			end else begin
				req = REQ_TICK;
			end
			send_request(req, id, per, 1'b0, '0);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
